/* rtl/core/atrp_pkg.sv */
// Shared types and constants for the answer-to-reset parser.
// Payload structs, status codes and ISO default field values.
// No dependencies.
package atrp_pkg;

  // Number of interface groups that may be recorded
  localparam int unsigned MaxGroupsDef = 8;

  // TS value for the inverse convention
  localparam logic [7:0] TsInverse = 8'h3F;

  // ISO defaults for absent fields
  localparam logic [7:0] RateDefault  = 8'h11;
  localparam logic [7:0] GuardDefault = 8'h00;
  localparam logic [3:0] ProtoDefault = 4'h0;
  localparam logic [7:0] IfscDefault  = 8'd32;
  localparam logic [7:0] WaitDefault  = 8'h4D;

  // Protocol numbers that are supported
  localparam logic [3:0] ProtoT0 = 4'd0;
  localparam logic [3:0] ProtoT1 = 4'd1;

  typedef enum logic [1:0] {
    StatusOk          = 2'd0,
    StatusUnsupported = 2'd1,
    StatusEarlyEnd    = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    PhTs    = 5'b00001,
    PhT0    = 5'b00010,
    PhIface = 5'b00100,
    PhHist  = 5'b01000,
    PhTail  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] atr_byte;
    logic       last_byte;
  } atrp_in_t;

  typedef struct packed {
    logic       checksum_ok;
    logic       inverse_convention;
    logic [7:0] rate_indices;
    logic [7:0] extra_guard;
    logic [3:0] protocol_type;
    logic [7:0] field_size;
    logic [7:0] wait_indices;
    logic [3:0] history_count;
    status_e    status;
  } atrp_res_t;

endpackage

/* rtl/core/atrp_in_stage.sv */
// Input register of the answer-to-reset parser.
// Holds one request until the parse stage consumes it; uses atrp_pkg.
module atrp_in_stage import atrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  atrp_in_t in_req_i,
  input  logic     consume_i,
  output logic     item_valid_o,
  output atrp_in_t item_o
);

  logic     valid_q, valid_d;
  atrp_in_t item_q;

  // Take a new request when empty or when the held one leaves this cycle
  assign in_ready_o = !valid_q || consume_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !consume_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_req_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/core/atrp_parse.sv */
// Byte-serial parse stage: phase, indicator and capture registers.
// Advances the state by one byte per enable and forms the result; uses atrp_pkg.
module atrp_parse import atrp_pkg::*; #(
  parameter int unsigned MaxGroups = MaxGroupsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  atrp_in_t  item_i,
  output logic      res_valid_o,
  output atrp_res_t res_o
);

  localparam int unsigned GroupW = $clog2(MaxGroups + 1);

  phase_e            phase_q, phase_d;
  logic [3:0]        pend_q, pend_d;
  logic [GroupW-1:0] group_q, group_d;
  logic [3:0]        hist_left_q, hist_left_d;
  logic [7:0]        xor_q, xor_d;
  logic [7:0]        rate_q, rate_d;
  logic [7:0]        guard_q, guard_d;
  logic [3:0]        proto_q, proto_d;
  logic [7:0]        ifsc_q, ifsc_d;
  logic [7:0]        wait_q, wait_d;
  logic [3:0]        hist_cnt_q, hist_cnt_d;
  logic              inv_q, inv_d;
  logic              unsup_q, unsup_d;
  logic              ovf_q, ovf_d;

  logic [7:0] b;
  logic       rec;
  logic       first_grp;
  logic       late_grp;
  logic       early;

  assign b         = item_i.atr_byte;
  assign rec       = !unsup_q && !ovf_q;
  assign first_grp = (group_q == GroupW'(1));
  assign late_grp  = (group_q > GroupW'(2));

  // Advance the parse state by one byte
  always_comb begin
    phase_d     = phase_q;
    pend_d      = pend_q;
    group_d     = group_q;
    hist_left_d = hist_left_q;
    xor_d       = xor_q;
    rate_d      = rate_q;
    guard_d     = guard_q;
    proto_d     = proto_q;
    ifsc_d      = ifsc_q;
    wait_d      = wait_q;
    hist_cnt_d  = hist_cnt_q;
    inv_d       = inv_q;
    unsup_d     = unsup_q;
    ovf_d       = ovf_q;

    unique case (phase_q)
      PhTs: begin
        inv_d   = (b == TsInverse);
        phase_d = PhT0;
      end
      PhT0: begin
        xor_d       = xor_q ^ b;
        pend_d      = b[7:4];
        hist_left_d = b[3:0];
        hist_cnt_d  = b[3:0];
        group_d     = GroupW'(1);
        if (b[7:4] == 4'd0) begin
          phase_d = (b[3:0] != 4'd0) ? PhHist : PhTail;
        end else begin
          phase_d = PhIface;
        end
      end
      PhIface: begin
        xor_d = xor_q ^ b;
        priority if (pend_q[0]) begin
          // TA byte
          pend_d = pend_q & 4'b1110;
          if (rec && first_grp) rate_d = b;
          if (rec && late_grp && proto_q == ProtoT1) ifsc_d = b;
        end else if (pend_q[1]) begin
          // TB byte
          pend_d = pend_q & 4'b1100;
          if (rec && late_grp) wait_d = b;
        end else if (pend_q[2]) begin
          // TC byte
          pend_d = pend_q & 4'b1000;
          if (rec && first_grp) guard_d = b;
        end else begin
          // TD byte: next indicator nibble
          pend_d = b[7:4];
          if (rec && first_grp) begin
            proto_d = b[3:0];
            if (b[3:0] != ProtoT0 && b[3:0] != ProtoT1) unsup_d = 1'b1;
          end
          if (group_q < GroupW'(MaxGroups)) begin
            group_d = group_q + GroupW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (pend_d == 4'd0) begin
          phase_d = (hist_left_q != 4'd0) ? PhHist : PhTail;
        end
      end
      PhHist: begin
        xor_d = xor_q ^ b;
        if (hist_left_q != 4'd0) hist_left_d = hist_left_q - 4'd1;
        if (hist_left_d == 4'd0) phase_d = PhTail;
      end
      PhTail: begin
        xor_d = xor_q ^ b;
      end
      default: begin
        phase_d = PhTs;
      end
    endcase
  end

  // Form the result from the updated state
  assign early = (phase_q == PhTs);

  always_comb begin
    res_o.checksum_ok        = !early && (xor_d == 8'd0);
    res_o.inverse_convention = inv_d;
    res_o.rate_indices       = rate_d;
    res_o.extra_guard        = guard_d;
    res_o.protocol_type      = proto_d;
    res_o.field_size         = ifsc_d;
    res_o.wait_indices       = wait_d;
    res_o.history_count      = early ? 4'd0 : hist_cnt_d;
    if (early) begin
      res_o.status = StatusEarlyEnd;
    end else if (unsup_d) begin
      res_o.status = StatusUnsupported;
    end else begin
      res_o.status = StatusOk;
    end
  end

  assign res_valid_o = step_i && item_i.last_byte;

  // Hold state; return to defaults after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhTs;
      pend_q      <= 4'd0;
      group_q     <= GroupW'(1);
      hist_left_q <= 4'd0;
      xor_q       <= 8'd0;
      rate_q      <= RateDefault;
      guard_q     <= GuardDefault;
      proto_q     <= ProtoDefault;
      ifsc_q      <= IfscDefault;
      wait_q      <= WaitDefault;
      hist_cnt_q  <= 4'd0;
      inv_q       <= 1'b0;
      unsup_q     <= 1'b0;
      ovf_q       <= 1'b0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        phase_q     <= PhTs;
        pend_q      <= 4'd0;
        group_q     <= GroupW'(1);
        hist_left_q <= 4'd0;
        xor_q       <= 8'd0;
        rate_q      <= RateDefault;
        guard_q     <= GuardDefault;
        proto_q     <= ProtoDefault;
        ifsc_q      <= IfscDefault;
        wait_q      <= WaitDefault;
        hist_cnt_q  <= 4'd0;
        inv_q       <= 1'b0;
        unsup_q     <= 1'b0;
        ovf_q       <= 1'b0;
      end else begin
        phase_q     <= phase_d;
        pend_q      <= pend_d;
        group_q     <= group_d;
        hist_left_q <= hist_left_d;
        xor_q       <= xor_d;
        rate_q      <= rate_d;
        guard_q     <= guard_d;
        proto_q     <= proto_d;
        ifsc_q      <= ifsc_d;
        wait_q      <= wait_d;
        hist_cnt_q  <= hist_cnt_d;
        inv_q       <= inv_d;
        unsup_q     <= unsup_d;
        ovf_q       <= ovf_d;
      end
    end
  end

endmodule

/* rtl/core/atrp_out_stage.sv */
// Result register of the answer-to-reset parser.
// Holds one result until the consumer takes it; uses atrp_pkg.
module atrp_out_stage import atrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  atrp_res_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output atrp_res_t out_res_o
);

  logic      valid_q, valid_d;
  atrp_res_t res_q;

  // Free when empty or when the held result leaves this cycle
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

/* rtl/core/smart_card_atr_parser.sv */
// Answer-to-reset parser, top level: input register, parse stage, result register.
// Depends on atrp_pkg, atrp_in_stage, atrp_parse and atrp_out_stage.
//
// Feed the answer-to-reset one byte per request, starting at TS, with
// last_byte set on the final byte. The block takes one byte every cycle
// while no last byte waits for a held result register; each byte is parsed
// combinationally out of the input register, so the rate is one byte per
// clock under that condition. A last byte is taken into the input register,
// parsed, and its result loaded into the result register; it carries TS
// convention, TA1, TC1, the TD1 protocol, IFSC, BWI/CWI, the historical
// byte count, the TCK check and a status code; absent fields read as ISO
// defaults. After the last byte the parser returns to its reset state, so
// the next answer-to-reset may follow at once. Input stalls only while a
// last byte waits for a result register that is still held.
module smart_card_atr_parser import atrp_pkg::*; #(
  parameter int unsigned MaxGroups = MaxGroupsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  atrp_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output atrp_res_t out_res_o
);

  logic      item_valid;
  atrp_in_t  item;
  logic      step;
  logic      out_free;
  logic      res_valid;
  atrp_res_t res;

  // Advance unless a last byte waits for the result register
  assign step = item_valid && (!item.last_byte || out_free);

  atrp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .consume_i   (step),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  atrp_parse #(
    .MaxGroups(MaxGroups)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  atrp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

endmodule
